### hdl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants of the open addressing hash table
// Sizes, request and response items, operation and status codes, and the
// read and write structs that pass between the prober and the slot store.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Table geometry. BUCKETS must be a power of two.
    localparam int BUCKETS    = 256;
    localparam int IDX_W      = $clog2(BUCKETS);
    localparam int STEP_W     = IDX_W + 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int FILL_LIMIT = BUCKETS / 2 - 1;

    // Field widths of the items.
    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int HASH_W  = 32;
    localparam int VALUE_W = 32;

    // Operation codes; any other code behaves as a get.
    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Request item.
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] value;
    } t_req;

    // Response item.
    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value_out;
        logic               status;
    } t_rsp;

    // Slot contents as read from the store through its registered read port.
    typedef struct packed {
        logic               valid;
        logic               tomb;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot_rd;

    // Write command into the store.
    typedef struct packed {
        logic               tag_we;
        logic               val_we;
        logic [IDX_W-1:0]   addr;
        logic               tomb;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_slot_wr;

endpackage

### hdl/oaht_store.sv
// ----------------------------------------------------------------------------
// oaht_store: slot storage of the hash table
// A tag memory (tombstone flag and key) and a value memory, both with a
// registered read, plus one occupancy flag per slot cleared at reset.
// ----------------------------------------------------------------------------
module oaht_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [oaht_pkg::IDX_W-1:0]    i_rd_addr,
    input  oaht_pkg::t_slot_wr            i_wr,
    output oaht_pkg::t_slot_rd            o_rd
);

    logic [oaht_pkg::KEY_W:0]     r_tag_mem [oaht_pkg::BUCKETS];
    logic [oaht_pkg::VALUE_W-1:0] r_val_mem [oaht_pkg::BUCKETS];
    logic [oaht_pkg::BUCKETS-1:0] r_used;
    logic [oaht_pkg::KEY_W:0]     r_tag_rd;
    logic [oaht_pkg::VALUE_W-1:0] r_val_rd;
    logic                         r_used_rd;

    // Tag memory: a slot written here is never empty again.
    always_ff @(posedge i_clk) begin
        if (i_wr.tag_we) begin
            r_tag_mem[i_wr.addr] <= {i_wr.tomb, i_wr.key};
        end
        r_tag_rd <= r_tag_mem[i_rd_addr];
    end

    // Value memory.
    always_ff @(posedge i_clk) begin
        if (i_wr.val_we) begin
            r_val_mem[i_wr.addr] <= i_wr.value;
        end
        r_val_rd <= r_val_mem[i_rd_addr];
    end

    // Occupancy flags: a slot that was never written reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.tag_we) begin
            r_used[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_used_rd <= r_used[i_rd_addr];
    end

    assign o_rd.valid = r_used_rd;
    assign o_rd.tomb  = r_tag_rd[oaht_pkg::KEY_W];
    assign o_rd.key   = r_tag_rd[oaht_pkg::KEY_W-1:0];
    assign o_rd.value = r_val_rd;

endmodule

### hdl/oaht_probe.sv
// ----------------------------------------------------------------------------
// oaht_probe: probe sequencer of the hash table
// Walks the triangular probe path one slot per cycle, tracks the first
// tombstone, applies the update and registers the response item.
// ----------------------------------------------------------------------------
module oaht_probe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  oaht_pkg::t_req                i_req,
    input  oaht_pkg::t_slot_rd            i_rd,
    output logic [oaht_pkg::IDX_W-1:0]    o_rd_addr,
    output oaht_pkg::t_slot_wr            o_wr,
    output logic                          o_busy,
    output logic                          o_done,
    output oaht_pkg::t_rsp                o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PROBE = 2'b10
    } t_state;

    t_state                           r_state, n_state;
    oaht_pkg::t_req                   r_req, n_req;
    logic [oaht_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [oaht_pkg::STEP_W-1:0]      r_step, n_step;
    logic                             r_tomb_seen, n_tomb_seen;
    logic [oaht_pkg::IDX_W-1:0]       r_tomb_idx, n_tomb_idx;
    logic [oaht_pkg::CNT_W-1:0]       r_used_cnt, n_used_cnt;
    logic [oaht_pkg::CNT_W-1:0]       r_tomb_cnt, n_tomb_cnt;
    logic                             r_done, n_done;
    oaht_pkg::t_rsp                   r_rsp, n_rsp;

    logic                             cur_empty;
    logic                             cur_tomb;
    logic                             hit;
    logic                             last;
    logic                             eff_tomb_seen;
    logic [oaht_pkg::IDX_W-1:0]       eff_tomb_idx;
    logic [oaht_pkg::IDX_W-1:0]       nxt_idx;
    logic [oaht_pkg::IDX_W-1:0]       slot;
    logic                             have_slot;

    // Classification of the slot read in this cycle.
    always_comb begin
        cur_empty     = !i_rd.valid;
        cur_tomb      = i_rd.valid && i_rd.tomb;
        hit           = i_rd.valid && !i_rd.tomb && (i_rd.key == r_req.key);
        last          = cur_empty || hit
                        || (r_step == oaht_pkg::STEP_W'(oaht_pkg::BUCKETS));
        eff_tomb_seen = r_tomb_seen || cur_tomb;
        eff_tomb_idx  = r_tomb_seen ? r_tomb_idx : r_idx;
        nxt_idx       = r_idx + r_step[oaht_pkg::IDX_W-1:0];
        have_slot     = cur_empty || eff_tomb_seen;
        slot          = eff_tomb_seen ? eff_tomb_idx : r_idx;
    end

    // Next state, store access and response.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_step      = r_step;
        n_tomb_seen = r_tomb_seen;
        n_tomb_idx  = r_tomb_idx;
        n_used_cnt  = r_used_cnt;
        n_tomb_cnt  = r_tomb_cnt;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        o_rd_addr   = nxt_idx;
        o_wr        = '0;
        o_wr.key    = r_req.key;
        o_wr.value  = r_req.value;

        unique case (r_state)
            ST_IDLE: begin
                o_rd_addr = i_req.key_hash[oaht_pkg::IDX_W-1:0];
                if (i_start) begin
                    n_state     = ST_PROBE;
                    n_req       = i_req;
                    n_idx       = i_req.key_hash[oaht_pkg::IDX_W-1:0];
                    n_step      = oaht_pkg::STEP_W'(1);
                    n_tomb_seen = 1'b0;
                end
            end
            ST_PROBE: begin
                if (!last) begin
                    // Keep walking; remember the first tombstone only.
                    n_idx       = nxt_idx;
                    n_step      = r_step + oaht_pkg::STEP_W'(1);
                    n_tomb_seen = eff_tomb_seen;
                    n_tomb_idx  = eff_tomb_idx;
                end else begin
                    n_state         = ST_IDLE;
                    n_done          = 1'b1;
                    n_rsp.found     = hit;
                    n_rsp.value_out = hit ? i_rd.value : '0;
                    n_rsp.status    = oaht_pkg::STATUS_DONE;
                    if (r_req.operation == oaht_pkg::OP_SET) begin
                        priority if (hit) begin
                            // Replace in place.
                            o_wr.val_we = 1'b1;
                            o_wr.addr   = r_idx;
                        end else if (have_slot && eff_tomb_seen) begin
                            // Reuse the first tombstone on the path.
                            o_wr.tag_we = 1'b1;
                            o_wr.val_we = 1'b1;
                            o_wr.addr   = slot;
                            if (r_tomb_cnt != '0) begin
                                n_tomb_cnt = r_tomb_cnt - oaht_pkg::CNT_W'(1);
                            end
                        end else if (have_slot && (r_used_cnt
                                     < oaht_pkg::CNT_W'(oaht_pkg::FILL_LIMIT))) begin
                            // Fresh empty slot.
                            o_wr.tag_we = 1'b1;
                            o_wr.val_we = 1'b1;
                            o_wr.addr   = slot;
                            n_used_cnt  = r_used_cnt + oaht_pkg::CNT_W'(1);
                        end else begin
                            n_rsp.status = oaht_pkg::STATUS_FULL;
                        end
                    end else if (r_req.operation == oaht_pkg::OP_REMOVE) begin
                        if (hit) begin
                            o_wr.tag_we = 1'b1;
                            o_wr.tomb   = 1'b1;
                            o_wr.addr   = r_idx;
                            n_tomb_cnt  = r_tomb_cnt + oaht_pkg::CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used_cnt <= '0;
            r_tomb_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used_cnt <= n_used_cnt;
            r_tomb_cnt <= n_tomb_cnt;
            r_done     <= n_done;
        end
    end

    // Payload and probe registers.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_idx       <= n_idx;
        r_step      <= n_step;
        r_tomb_seen <= n_tomb_seen;
        r_tomb_idx  <= n_tomb_idx;
        r_rsp       <= n_rsp;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef NO_ASSERTIONS
    // The fill limit bounds the number of used slots.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= oaht_pkg::CNT_W'(oaht_pkg::FILL_LIMIT))
        else $error("used slot count above fill limit");

    // Tombstones are a subset of the used slots.
    a_tomb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tomb_cnt <= r_used_cnt)
        else $error("tombstone count above used count");

    // A response follows the last probe cycle and leaves the sequencer idle.
    a_done_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == ST_PROBE) && (r_state == ST_IDLE))
        else $error("response item without a finished probe");

    // A refused set never reports a hit.
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == oaht_pkg::STATUS_FULL) |-> !o_rsp.found)
        else $error("full status together with found");

    // The store is written only in the last probe cycle.
    a_write_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.tag_we || o_wr.val_we) |=> o_done)
        else $error("store write without a response item");
`endif

endmodule

### hdl/open_addressing_hash_table_unit.sv
// Probing: a request probes k slots (1 to BUCKETS) one per cycle; its result
// strobe o_done is high for one cycle, registered after the last probe.
// Requests: one at a time, ignored while busy; the next start is taken in the
// cycle the result is shown. The probe walk through the slot memories sets k.
// Reset clears the sequencer, the counters and the slot occupancy flags; there
// is no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// open_addressing_hash_table_unit: fixed-size hash table with open addressing
// Get, set and remove requests with triangular probing and tombstones; a set
// that needs a fresh slot is refused once the table reaches its fill limit.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  oaht_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output oaht_pkg::t_rsp o_rsp
);

    logic [oaht_pkg::IDX_W-1:0] rd_addr;
    oaht_pkg::t_slot_wr         slot_wr;
    oaht_pkg::t_slot_rd         slot_rd;

    // Probe sequencer.
    oaht_probe u_probe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .i_rd      (slot_rd),
        .o_rd_addr (rd_addr),
        .o_wr      (slot_wr),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp)
    );

    // Slot memories.
    oaht_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (slot_wr),
        .o_rd      (slot_rd)
    );

endmodule
